/* design/pmt_ca_pkg.sv */
// ----------------------------------------------------------------------------
// PMT CA parser package
// Shared widths, constants, phase and record codes, and transaction types.
// ----------------------------------------------------------------------------
package pmt_ca_pkg;

	// Largest buffer that is parsed; longer buffer lengths are clamped to it.
	localparam int MAX_BUFFER_BYTES = 4096;
	localparam int MIN_BUFFER_BYTES = 16;

	// Field and position widths.
	localparam int LEN_W = 13;
	localparam int SUM_W = LEN_W + 1;
	localparam int SEC_W = 12;
	localparam int PID_W = 13;
	localparam int CNT_W = 11;

	localparam logic [7:0]       TABLE_ID_PMT = 8'h02;
	localparam logic [7:0]       CA_DESC_TAG  = 8'h09;
	localparam logic [7:0]       CA_DESC_MIN  = 8'd4;
	localparam logic [CNT_W-1:0] CNT_MAX      = '1;

	// Parse phase of the section walk.
	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_HEAD  = 4'd1,
		PH_PTAG  = 4'd2,
		PH_PLEN  = 4'd3,
		PH_PBODY = 4'd4,
		PH_SHDR  = 4'd5,
		PH_ETAG  = 4'd6,
		PH_ELEN  = 4'd7,
		PH_EBODY = 4'd8,
		PH_TAIL  = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		KIND_PROG_CA   = 3'd0,
		KIND_STREAM    = 3'd1,
		KIND_STREAM_CA = 3'd2,
		KIND_DONE      = 3'd3,
		KIND_ERROR     = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SHORT     = 3'd1,
		ERR_TABLE_ID  = 3'd2,
		ERR_SEC_LONG  = 3'd3,
		ERR_PROG_INFO = 3'd4
	} err_t;

	// One input transaction.
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             section_start;
		logic [LEN_W-1:0] buffer_length;
	} item_t;

	// One result transaction.
	typedef struct packed {
		kind_t            record_kind;
		err_t             error_code;
		logic [15:0]      program_number;
		logic [PID_W-1:0] pcr_pid;
		logic [7:0]       stream_type;
		logic [PID_W-1:0] elementary_pid;
		logic [15:0]      ca_system_id;
		logic [PID_W-1:0] ca_pid;
		logic [CNT_W-1:0] stream_total;
		logic [CNT_W-1:0] program_ca_total;
	} result_t;

endpackage

/* design/pmt_ca_in_if.sv */
// ----------------------------------------------------------------------------
// PMT CA parser byte channel
// Valid/ready channel that carries one section byte per transaction.
// ----------------------------------------------------------------------------
interface pmt_ca_in_if import pmt_ca_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [7:0]       data_byte;
	logic             section_start;
	logic [LEN_W-1:0] buffer_length;

	modport source(output valid, data_byte, section_start, buffer_length, input ready);
	modport sink(input valid, data_byte, section_start, buffer_length, output ready);

endinterface

/* design/pmt_ca_out_if.sv */
// ----------------------------------------------------------------------------
// PMT CA parser record channel
// Valid/ready channel that carries one parse record per transaction.
// ----------------------------------------------------------------------------
interface pmt_ca_out_if import pmt_ca_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [2:0]       record_kind;
	logic [2:0]       error_code;
	logic [15:0]      program_number;
	logic [PID_W-1:0] pcr_pid;
	logic [7:0]       stream_type;
	logic [PID_W-1:0] elementary_pid;
	logic [15:0]      ca_system_id;
	logic [PID_W-1:0] ca_pid;
	logic [CNT_W-1:0] stream_total;
	logic [CNT_W-1:0] program_ca_total;

	modport source(output valid, record_kind, error_code, program_number, pcr_pid,
		stream_type, elementary_pid, ca_system_id, ca_pid, stream_total,
		program_ca_total, input ready);
	modport sink(input valid, record_kind, error_code, program_number, pcr_pid,
		stream_type, elementary_pid, ca_system_id, ca_pid, stream_total,
		program_ca_total, output ready);

endinterface

/* design/pmt_ca_walk.sv */
// ----------------------------------------------------------------------------
// PMT CA parser section walker
// Holds the parse state and steps it by one section byte, producing at most
// one record for that byte.
// ----------------------------------------------------------------------------
module pmt_ca_walk import pmt_ca_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	// Parse state.
	phase_t           phase_q, n_phase;
	logic [LEN_W-1:0] pos_q, n_pos;
	logic [LEN_W-1:0] total_q, n_total;
	logic [SEC_W-1:0] sec_len_q, n_sec_len;
	logic [15:0]      prog_num_q, n_prog_num;
	logic [PID_W-1:0] pcr_q, n_pcr;
	logic [LEN_W-1:0] pinfo_end_q, n_pinfo_end;
	logic [LEN_W-1:0] desc_end_q, n_desc_end;
	logic [LEN_W-1:0] sinfo_end_q, n_sinfo_end;
	logic [7:0]       tag_q, n_tag;
	logic [7:0]       dlen_q, n_dlen;
	logic [7:0]       stype_q, n_stype;
	logic [PID_W-1:0] spid_q, n_spid;
	logic [15:0]      ca_id_q, n_ca_id;
	logic [CNT_W-1:0] stream_cnt_q, n_stream_cnt;
	logic [CNT_W-1:0] pca_cnt_q, n_pca_cnt;
	logic [LEN_W-1:0] item_start_q, n_item_start;
	logic [4:0]       ca_pid_hi_q, n_ca_pid_hi;

	// Per-byte working values.
	logic [7:0]       b;
	logic [LEN_W-1:0] len_clamped;
	logic [LEN_W-1:0] pos_inc;
	logic [SUM_W-1:0] c;
	logic [LEN_W-1:0] rel;
	logic [SEC_W-1:0] sec_end;
	logic [SEC_W-1:0] sl_full;
	logic [LEN_W-1:0] pe_full;
	logic [LEN_W-1:0] lim;
	logic [SUM_W-1:0] c_plus_b;
	logic [SEC_W-1:0] eil;
	logic [SUM_W-1:0] c_plus_eil;
	logic             prog;

	// Phase after the end of the program loop or of a stream.
	function automatic phase_t stream_next_ph(input logic [SUM_W-1:0] cc,
		input logic [SEC_W-1:0] se);
		return ((cc + SUM_W'(5)) <= SUM_W'(se)) ? PH_SHDR : PH_TAIL;
	endfunction

	// Phase after a descriptor inside a loop that ends at lim_end.
	function automatic phase_t loop_next_ph(input logic [SUM_W-1:0] cc,
		input logic [LEN_W-1:0] lim_end, input phase_t tag_ph,
		input logic [SEC_W-1:0] se);
		return ((cc + SUM_W'(2)) <= SUM_W'(lim_end)) ? tag_ph : stream_next_ph(cc, se);
	endfunction

	// Next state and result for the byte in the input register.
	always_comb begin
		n_phase      = phase_q;
		n_pos        = pos_q;
		n_total      = total_q;
		n_sec_len    = sec_len_q;
		n_prog_num   = prog_num_q;
		n_pcr        = pcr_q;
		n_pinfo_end  = pinfo_end_q;
		n_desc_end   = desc_end_q;
		n_sinfo_end  = sinfo_end_q;
		n_tag        = tag_q;
		n_dlen       = dlen_q;
		n_stype      = stype_q;
		n_spid       = spid_q;
		n_ca_id      = ca_id_q;
		n_stream_cnt = stream_cnt_q;
		n_pca_cnt    = pca_cnt_q;
		n_item_start = item_start_q;
		n_ca_pid_hi  = ca_pid_hi_q;
		res_valid    = 1'b0;
		res          = '0;

		b           = item.data_byte;
		len_clamped = (item.buffer_length > LEN_W'(MAX_BUFFER_BYTES)) ?
			LEN_W'(MAX_BUFFER_BYTES) : item.buffer_length;
		pos_inc     = pos_q + LEN_W'(1);
		c           = SUM_W'(pos_inc) + SUM_W'(1);
		rel         = pos_inc - item_start_q;
		sec_end     = (sec_len_q < SEC_W'(4)) ? '0 : sec_len_q - SEC_W'(1);
		sl_full     = sec_len_q | SEC_W'(b);
		pe_full     = LEN_W'(12) + (pinfo_end_q | LEN_W'(b));
		prog        = (phase_q == PH_PLEN) || (phase_q == PH_PBODY);
		lim         = prog ? pinfo_end_q : sinfo_end_q;
		c_plus_b    = c + SUM_W'(b);
		eil         = sinfo_end_q[SEC_W-1:0] | SEC_W'(b);
		c_plus_eil  = c + SUM_W'(eil);

		if (step) begin
			if (item.section_start) begin
				// A section start restarts the parse from a clean state.
				n_phase      = PH_HEAD;
				n_pos        = '0;
				n_total      = len_clamped;
				n_sec_len    = '0;
				n_prog_num   = '0;
				n_pcr        = '0;
				n_pinfo_end  = '0;
				n_desc_end   = '0;
				n_sinfo_end  = '0;
				n_tag        = '0;
				n_dlen       = '0;
				n_stype      = '0;
				n_spid       = '0;
				n_ca_id      = '0;
				n_stream_cnt = '0;
				n_pca_cnt    = '0;
				n_item_start = '0;
				n_ca_pid_hi  = '0;
				if (len_clamped < LEN_W'(MIN_BUFFER_BYTES)) begin
					n_phase          = PH_IDLE;
					res_valid        = 1'b1;
					res.record_kind  = KIND_ERROR;
					res.error_code   = ERR_SHORT;
				end else if (b != TABLE_ID_PMT) begin
					n_phase          = PH_IDLE;
					res_valid        = 1'b1;
					res.record_kind  = KIND_ERROR;
					res.error_code   = ERR_TABLE_ID;
				end
			end else if (phase_q != PH_IDLE) begin
				n_pos = pos_inc;
				unique case (phase_q)
					PH_HEAD: begin
						// Fixed header fields by byte position.
						unique case (pos_inc)
							LEN_W'(1): n_sec_len = {b[3:0], 8'h00};
							LEN_W'(2): begin
								n_sec_len = sl_full;
								if ((SUM_W'(sl_full) + SUM_W'(3)) > SUM_W'(total_q)) begin
									n_phase         = PH_IDLE;
									res_valid       = 1'b1;
									res.record_kind = KIND_ERROR;
									res.error_code  = ERR_SEC_LONG;
								end
							end
							LEN_W'(3): n_prog_num = {b, 8'h00};
							LEN_W'(4): n_prog_num = prog_num_q | 16'(b);
							LEN_W'(8): n_pcr = {b[4:0], 8'h00};
							LEN_W'(9): n_pcr = pcr_q | PID_W'(b);
							LEN_W'(10): n_pinfo_end = LEN_W'({b[3:0], 8'h00});
							LEN_W'(11): begin
								n_pinfo_end = pe_full;
								if (pe_full > (total_q - LEN_W'(4))) begin
									n_phase         = PH_IDLE;
									res_valid       = 1'b1;
									res.record_kind = KIND_ERROR;
									res.error_code  = ERR_PROG_INFO;
								end else begin
									n_phase      = loop_next_ph(c, pe_full, PH_PTAG, sec_end);
									n_item_start = c[LEN_W-1:0];
								end
							end
							default: ;
						endcase
					end
					PH_PTAG, PH_ETAG: begin
						n_tag   = b;
						n_phase = (phase_q == PH_PTAG) ? PH_PLEN : PH_ELEN;
					end
					PH_PLEN, PH_ELEN: begin
						// Descriptor length: overrun, empty or a body to walk.
						n_dlen       = b;
						n_item_start = c[LEN_W-1:0];
						if (c_plus_b > SUM_W'(lim)) begin
							n_phase = stream_next_ph(c, sec_end);
						end else if (b == 8'd0) begin
							n_phase = loop_next_ph(c, lim, prog ? PH_PTAG : PH_ETAG, sec_end);
						end else begin
							n_desc_end = c_plus_b[LEN_W-1:0];
							n_phase    = prog ? PH_PBODY : PH_EBODY;
						end
					end
					PH_PBODY, PH_EBODY: begin
						// CA descriptor body: system id, then the ECM PID.
						if ((tag_q == CA_DESC_TAG) && (dlen_q >= CA_DESC_MIN)) begin
							unique case (rel)
								LEN_W'(0): n_ca_id = {b, 8'h00};
								LEN_W'(1): n_ca_id = ca_id_q | 16'(b);
								LEN_W'(2): n_ca_pid_hi = b[4:0];
								LEN_W'(3): begin
									res_valid          = 1'b1;
									res.program_number = prog_num_q;
									res.pcr_pid        = pcr_q;
									res.ca_system_id   = ca_id_q;
									res.ca_pid         = {ca_pid_hi_q, b};
									if (prog) begin
										res.record_kind = KIND_PROG_CA;
										if (pca_cnt_q != CNT_MAX) begin
											n_pca_cnt = pca_cnt_q + CNT_W'(1);
										end
									end else begin
										res.record_kind    = KIND_STREAM_CA;
										res.stream_type    = stype_q;
										res.elementary_pid = spid_q;
									end
								end
								default: ;
							endcase
						end
						if (c == SUM_W'(desc_end_q)) begin
							n_phase      = loop_next_ph(c, lim, prog ? PH_PTAG : PH_ETAG, sec_end);
							n_item_start = c[LEN_W-1:0];
						end
					end
					PH_SHDR: begin
						// Elementary stream header, five bytes.
						unique case (rel)
							LEN_W'(0): n_stype = b;
							LEN_W'(1): n_spid = {b[4:0], 8'h00};
							LEN_W'(2): n_spid = spid_q | PID_W'(b);
							LEN_W'(3): n_sinfo_end = LEN_W'({b[3:0], 8'h00});
							default: begin
								if (c_plus_eil > SUM_W'(sec_end)) begin
									n_phase = PH_TAIL;
								end else begin
									n_sinfo_end = c_plus_eil[LEN_W-1:0];
									if (stream_cnt_q != CNT_MAX) begin
										n_stream_cnt = stream_cnt_q + CNT_W'(1);
									end
									res_valid          = 1'b1;
									res.record_kind    = KIND_STREAM;
									res.program_number = prog_num_q;
									res.pcr_pid        = pcr_q;
									res.stream_type    = stype_q;
									res.elementary_pid = spid_q;
									n_phase      = loop_next_ph(c, c_plus_eil[LEN_W-1:0],
										PH_ETAG, sec_end);
									n_item_start = c[LEN_W-1:0];
								end
							end
						endcase
					end
					default: ;
				endcase

				// The last byte of the buffer closes the section unless it gave a record.
				if (!res_valid && (n_phase != PH_IDLE) &&
					((SUM_W'(pos_inc) + SUM_W'(1)) == SUM_W'(total_q))) begin
					n_phase              = PH_IDLE;
					res_valid            = 1'b1;
					res.record_kind      = KIND_DONE;
					res.program_number   = n_prog_num;
					res.pcr_pid          = n_pcr;
					res.stream_total     = n_stream_cnt;
					res.program_ca_total = n_pca_cnt;
				end
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pos_q        <= '0;
			total_q      <= '0;
			sec_len_q    <= '0;
			prog_num_q   <= '0;
			pcr_q        <= '0;
			pinfo_end_q  <= '0;
			desc_end_q   <= '0;
			sinfo_end_q  <= '0;
			tag_q        <= '0;
			dlen_q       <= '0;
			stype_q      <= '0;
			spid_q       <= '0;
			ca_id_q      <= '0;
			stream_cnt_q <= '0;
			pca_cnt_q    <= '0;
			item_start_q <= '0;
			ca_pid_hi_q  <= '0;
		end else begin
			phase_q      <= n_phase;
			pos_q        <= n_pos;
			total_q      <= n_total;
			sec_len_q    <= n_sec_len;
			prog_num_q   <= n_prog_num;
			pcr_q        <= n_pcr;
			pinfo_end_q  <= n_pinfo_end;
			desc_end_q   <= n_desc_end;
			sinfo_end_q  <= n_sinfo_end;
			tag_q        <= n_tag;
			dlen_q       <= n_dlen;
			stype_q      <= n_stype;
			spid_q       <= n_spid;
			ca_id_q      <= n_ca_id;
			stream_cnt_q <= n_stream_cnt;
			pca_cnt_q    <= n_pca_cnt;
			item_start_q <= n_item_start;
			ca_pid_hi_q  <= n_ca_pid_hi;
		end
	end

endmodule

/* design/pmt_ca_out_reg.sv */
// ----------------------------------------------------------------------------
// PMT CA parser result register
// Holds one record until the receiver takes it and reports when it has room.
// ----------------------------------------------------------------------------
module pmt_ca_out_reg import pmt_ca_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	output logic    space,
	pmt_ca_out_if.source rec
);

	logic    valid_q;
	result_t res_q;

	// Room when empty or when the held record leaves this cycle.
	assign space = !valid_q || rec.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rec.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign rec.valid            = valid_q;
	assign rec.record_kind      = res_q.record_kind;
	assign rec.error_code       = res_q.error_code;
	assign rec.program_number   = res_q.program_number;
	assign rec.pcr_pid          = res_q.pcr_pid;
	assign rec.stream_type      = res_q.stream_type;
	assign rec.elementary_pid   = res_q.elementary_pid;
	assign rec.ca_system_id     = res_q.ca_system_id;
	assign rec.ca_pid           = res_q.ca_pid;
	assign rec.stream_total     = res_q.stream_total;
	assign rec.program_ca_total = res_q.program_ca_total;

endmodule

/* design/pmt_section_ca_parser.sv */
// ----------------------------------------------------------------------------
// PMT section CA parser
// Walks a program map section byte by byte and reports CA descriptors,
// elementary stream headers, a done record and header errors.
//
// Usage:
// - bytes: one section byte per transaction; section_start marks the first
//   byte of a buffer and buffer_length is sampled with it.
// - records: at most one record per byte (program CA, stream header, stream
//   CA, section done or section error).
// - Path: a byte waits in the input register; its record is loaded into the
//   result register when that register has room and is taken from there.
// - Throughput: one byte per cycle while the result register has room; the
//   walker state updates once per byte.
// - Reset clears the valid flags of both registers and leaves the walker
//   idle; bytes before a section start are dropped without a record.
// - When the receiver stalls with a record held, an empty input register
//   still takes one more byte; further bytes wait until the record is taken.
// ----------------------------------------------------------------------------
module pmt_section_ca_parser import pmt_ca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pmt_ca_in_if.sink    bytes,
	pmt_ca_out_if.source records
);

	logic    valid_s1;
	item_t   item_s1;
	logic    space;
	logic    step;
	logic    res_valid;
	result_t res;

	// A byte is processed when the result register has room.
	assign step        = valid_s1 && space;
	assign bytes.ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			item_s1.data_byte     <= bytes.data_byte;
			item_s1.section_start <= bytes.section_start;
			item_s1.buffer_length <= bytes.buffer_length;
		end
	end

	pmt_ca_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	pmt_ca_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && res_valid),
		.res    (res),
		.space  (space),
		.rec    (records)
	);

endmodule
